// ===== src/iprd_pkg.sv =====
// Shared types and constants for the indexed pixel run decoder.
// No dependencies; imported by the decode stage and the top level.
package iprd_pkg;

  // Control byte thresholds for the two coding modes.
  localparam logic [7:0]  ZERO_RUN_BASE = 8'd128;
  localparam logic [7:0]  REPEAT_BASE   = 8'd192;

  // Largest image that the decoder tracks; larger sizes saturate here.
  localparam logic [30:0] MAX_PIXELS    = 31'h4000_0000;

  // Configuration register indexes.
  localparam logic        CFG_RUN_MODE     = 1'b0;
  localparam logic        CFG_TOTAL_PIXELS = 1'b1;

  // One accepted input beat.
  typedef struct packed {
    logic       last_byte;
    logic       first_byte;
    logic [7:0] source_byte;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic       short_input;
    logic       image_done;
    logic [7:0] run_length;
    logic [7:0] pixel_value;
  } result_t;

endpackage

// ===== src/indexed_pixel_run_decoder_core.sv =====
// An accepted beat passes from the input register through the decode stage into the result register that drives out_*.
// Throughput: one source byte per cycle, set by the single input register and
// the single result register around the decode stage; out_tready low stalls.
// Reset (rst_n low, synchronous) clears both stage valids and the decoding
// state, and sets run_mode to 0 and total_pixels to 1.
// Top level: input register, decode stage, result register, config registers.
module indexed_pixel_run_decoder_core import iprd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] source_byte
  input  logic        in_tuser,   // [0] first_byte
  input  logic        in_tlast,   // last_byte
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] pixel_value, [15:8] run_length
  output logic [1:0]  out_tuser,  // [0] image_done, [1] short_input
  // Configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [30:0] cfg_data
);

  logic     run_mode_r;
  logic [30:0] total_pixels_r;
  logic     in_valid_r, in_valid_nxt;
  in_beat_t in_beat_r;
  logic     out_valid_r, out_valid_nxt;
  result_t  out_res_r;
  logic     step;
  logic     res_valid;
  result_t  res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_mode_r     <= 1'b0;
      total_pixels_r <= 31'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RUN_MODE:     run_mode_r     <= cfg_data[0];
        CFG_TOTAL_PIXELS: total_pixels_r <= cfg_data;
        default:          ;
      endcase
    end
  end

  // The held beat is decoded whenever the result register can take it.
  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;

  always_comb begin
    in_valid_nxt = in_tready ? in_tvalid : in_valid_r;
    if (step) begin
      out_valid_nxt = res_valid;
    end else begin
      out_valid_nxt = out_valid_r && !out_tready;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_beat_r.source_byte <= in_tdata;
      in_beat_r.first_byte  <= in_tuser;
      in_beat_r.last_byte   <= in_tlast;
    end
  end

  iprd_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .run_mode     (run_mode_r),
    .total_pixels (total_pixels_r),
    .step_en      (step),
    .beat         (in_beat_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.run_length, out_res_r.pixel_value};
  assign out_tuser  = {out_res_r.short_input, out_res_r.image_done};

  // A finished image never also reports short input.
  a_done_not_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.image_done && out_res_r.short_input))
    else $error("image_done and short_input both set");

  // A status-only result carries pixel value zero.
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.run_length == 8'd0)) |-> (out_res_r.pixel_value == 8'd0))
    else $error("status result with nonzero pixel value");

  // No run is longer than ZERO_RUN_BASE.
  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.run_length <= ZERO_RUN_BASE))
    else $error("run length out of range");

  // A held beat with a free result register is always drained.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !out_valid_r) |-> in_tready)
    else $error("input stalled with free result register");

endmodule

// ===== src/iprd_decode.sv =====
// Decode stage: holds the per-image decoding state and turns one source byte
// into at most one run. Depends on iprd_pkg.
module iprd_decode import iprd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        run_mode,
  input  logic [30:0] total_pixels,
  input  logic        step_en,
  input  in_beat_t    beat,
  output logic        res_valid,
  output result_t     res
);

  logic [7:0]  literals_left_r, literals_left_nxt;
  logic        await_repeat_r, await_repeat_nxt;
  logic [5:0]  pending_repeat_r, pending_repeat_nxt;
  logic [30:0] pixels_made_r, pixels_made_nxt;

  logic [7:0]  lit_cur;
  logic        await_cur;
  logic [5:0]  pend_cur;
  logic [30:0] made_cur;
  logic [30:0] tot;
  logic [30:0] rem;
  logic        active;
  logic [7:0]  len_raw, len, val;

  always_comb begin
    // A first byte starts from cleared state.
    lit_cur   = beat.first_byte ? 8'd0  : literals_left_r;
    await_cur = beat.first_byte ? 1'b0  : await_repeat_r;
    pend_cur  = beat.first_byte ? 6'd0  : pending_repeat_r;
    made_cur  = beat.first_byte ? 31'd0 : pixels_made_r;

    // Image size saturates at the largest supported image.
    tot    = (total_pixels > MAX_PIXELS) ? MAX_PIXELS : total_pixels;
    active = made_cur < tot;
    rem    = tot - made_cur;

    literals_left_nxt  = lit_cur;
    await_repeat_nxt   = await_cur;
    pending_repeat_nxt = pend_cur;
    len_raw            = 8'd0;
    val                = 8'd0;

    // Per-mode byte interpretation; bytes after completion change nothing.
    if (active) begin
      if (run_mode) begin
        if (lit_cur != 8'd0) begin
          val               = beat.source_byte;
          len_raw           = 8'd1;
          literals_left_nxt = lit_cur - 8'd1;
        end else if (beat.source_byte > ZERO_RUN_BASE) begin
          len_raw = beat.source_byte - ZERO_RUN_BASE;
        end else begin
          literals_left_nxt = beat.source_byte;
        end
      end else begin
        if (await_cur) begin
          val                = beat.source_byte;
          len_raw            = {2'b00, pend_cur};
          await_repeat_nxt   = 1'b0;
          pending_repeat_nxt = 6'd0;
        end else if (beat.source_byte > REPEAT_BASE) begin
          pending_repeat_nxt = 6'(beat.source_byte - REPEAT_BASE);
          await_repeat_nxt   = 1'b1;
        end else begin
          val     = beat.source_byte;
          len_raw = 8'd1;
        end
      end
    end

    // Clip the run to the pixels still missing.
    if ((rem[30:8] == 23'd0) && (rem[7:0] < len_raw)) begin
      len = rem[7:0];
    end else begin
      len = len_raw;
    end
    pixels_made_nxt = made_cur + {23'd0, len};

    res_valid       = (len != 8'd0) || beat.last_byte;
    res.pixel_value = (len != 8'd0) ? val : 8'd0;
    res.run_length  = len;
    res.image_done  = pixels_made_nxt >= tot;
    res.short_input = beat.last_byte && !(pixels_made_nxt >= tot);
  end

  // Decoding state advances once per processed beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      literals_left_r  <= 8'd0;
      await_repeat_r   <= 1'b0;
      pending_repeat_r <= 6'd0;
      pixels_made_r    <= 31'd0;
    end else if (step_en) begin
      literals_left_r  <= literals_left_nxt;
      await_repeat_r   <= await_repeat_nxt;
      pending_repeat_r <= pending_repeat_nxt;
      pixels_made_r    <= pixels_made_nxt;
    end
  end

endmodule
